### rtl/cphd_pkg.sv
// ----------------------------------------------------------------------------
// cphd_pkg
// Types, register indexes and helpers for the hotplug decision core.
// ----------------------------------------------------------------------------
package cphd_pkg;

  localparam int LOAD_W  = 10;
  localparam int FREQ_W  = 22;
  localparam int CORE_W  = 3;
  localparam int TASK_W  = 16;
  localparam int QLEN_W  = 8;
  localparam int CLOAD_W = 7;
  localparam int TIME_W  = 16;
  localparam int THR_W   = 32;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 8;

  typedef enum logic [1:0] {
    DEC_NOP = 2'd0,
    DEC_IN  = 2'd1,
    DEC_OUT = 2'd2
  } decision_t;

  typedef enum logic [CFG_AW-1:0] {
    CFG_LOW_THR   = 3'd0,
    CFG_HIGH_THR  = 3'd1,
    CFG_MIN_FREQ  = 3'd2,
    CFG_QUEUE_LIM = 3'd3,
    CFG_LIGHT_LD  = 3'd4,
    CFG_TICK_TIME = 3'd5,
    CFG_MID_LIM   = 3'd6,
    CFG_HOLD_LIM  = 3'd7
  } cfg_index_t;

  typedef struct packed {
    logic [CLOAD_W-1:0] min_queue_core_load;
    logic [QLEN_W-1:0]  min_queue_len;
    logic [TASK_W-1:0]  runnable_tasks;
    logic [CORE_W-1:0]  cores_online;
    logic [FREQ_W-1:0]  current_freq;
    logic [LOAD_W-1:0]  total_load;
  } tick_t;

  function automatic logic [7:0] thr_byte(input logic [THR_W-1:0] r, input logic [1:0] k);
    logic [7:0] b;
    case (k)
      2'd0:    b = r[7:0];
      2'd1:    b = r[15:8];
      2'd2:    b = r[23:16];
      default: b = r[31:24];
    endcase
    return b;
  endfunction

endpackage

### rtl/cpu_hotplug_decision_core.sv
// ----------------------------------------------------------------------------
// cpu_hotplug_decision_core
// Per-tick core plug-in / plug-out decision with mid-band and hold timers.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   one sampling tick
// m_axis    out  m_axis_tvalid/m_axis_tready   one decision per tick
// cfg       in   cfg_valid/cfg_ready           cfg_addr, cfg_data
//
// An input register, then one pass of compare and timer update logic into
// the result register. One tick per cycle while the result is not stalled.
// Reset clears both timers, the valid flags and loads register defaults.
// A stalled result holds the result register; the input stage keeps
// accepting while it is empty. cfg_ready is always high.
// ----------------------------------------------------------------------------
module cpu_hotplug_decision_core
  import cphd_pkg::*;
#(
  parameter int MAX_CORES = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // total_load[9:0], current_freq[31:10], cores_online[34:32],
  // runnable_tasks[50:35], min_queue_len[58:51], min_queue_core_load[65:59]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // decision[1:0]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_AW-1:0]      cfg_addr,
  input  logic [CFG_DW-1:0]      cfg_data
);

  localparam int NB = $clog2(MAX_CORES + 1);
  localparam int CW = (NB > CORE_W) ? NB : CORE_W;
  localparam logic [CW-1:0] N_MAX = CW'(MAX_CORES);

  logic [THR_W-1:0]   low_thresholds;
  logic [THR_W-1:0]   high_thresholds;
  logic [FREQ_W-1:0]  min_frequency;
  logic [QLEN_W-1:0]  queue_limit;
  logic [CLOAD_W-1:0] light_core_load;
  logic [TIME_W-1:0]  tick_time;
  logic [TIME_W-1:0]  midband_limit;
  logic [TIME_W-1:0]  out_hold_limit;

  logic [TIME_W-1:0]  midband_time, midband_time_next;
  logic [TIME_W-1:0]  out_hold_time, out_hold_time_next;

  logic      in_valid;
  tick_t     in_tick;
  logic      res_valid;
  decision_t res_dec;
  decision_t dec_next;
  logic      advance;

  assign cfg_ready     = 1'b1;
  assign advance       = in_valid && (!res_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata  = {{(OUT_TDATA_W-2){1'b0}}, res_dec};

  always_ff @(posedge clk) begin
    if (rst) begin
      low_thresholds  <= '0;
      high_thresholds <= 32'h6464_6464;
      min_frequency   <= '0;
      queue_limit     <= 8'd2;
      light_core_load <= 7'd20;
      tick_time       <= 16'd500;
      midband_limit   <= 16'd8000;
      out_hold_limit  <= 16'd2000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index_t'(cfg_addr))
        CFG_LOW_THR:   low_thresholds  <= cfg_data;
        CFG_HIGH_THR:  high_thresholds <= cfg_data;
        CFG_MIN_FREQ:  min_frequency   <= cfg_data[FREQ_W-1:0];
        CFG_QUEUE_LIM: queue_limit     <= cfg_data[QLEN_W-1:0];
        CFG_LIGHT_LD:  light_core_load <= cfg_data[CLOAD_W-1:0];
        CFG_TICK_TIME: tick_time       <= cfg_data[TIME_W-1:0];
        CFG_MID_LIM:   midband_limit   <= cfg_data[TIME_W-1:0];
        CFG_HOLD_LIM:  out_hold_limit  <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_tick <= tick_t'(s_axis_tdata[$bits(tick_t)-1:0]);
    end
  end

  logic [CW-1:0]       n;
  logic [CW-1:0]       k_full, kp_full;
  logic [1:0]          k, kp;
  logic [7:0]          lo, hi, hi_prev;
  logic                multi;
  logic [LOAD_W-1:0]   load;
  logic [TIME_W:0]     mid_sum, hold_sum;
  logic [TIME_W-1:0]   mid_sat;
  logic                below, above, mid_low, mid_top;
  decision_t           flag;
  logic                mid_timeout;

  always_comb begin
    n = CW'(in_tick.cores_online);
    if (n == '0) begin
      n = CW'(1);
    end
    if (n > N_MAX) begin
      n = N_MAX;
    end
    k_full  = n - CW'(1);
    kp_full = n - CW'(2);
    k       = (k_full > CW'(3)) ? 2'd3 : k_full[1:0];
    kp      = (kp_full > CW'(3)) ? 2'd3 : kp_full[1:0];
    multi   = n > CW'(1);
    lo      = thr_byte(low_thresholds, k);
    hi      = thr_byte(high_thresholds, k);
    hi_prev = multi ? thr_byte(high_thresholds, kp) : 8'd0;
    load    = in_tick.total_load;
    below   = load < LOAD_W'(lo);
    above   = load > LOAD_W'(hi);
    mid_top = (load >= LOAD_W'(hi_prev)) && (load <= LOAD_W'(hi));
    mid_low = (load >= LOAD_W'(lo)) && (load < LOAD_W'(hi_prev));
    mid_sum = {1'b0, midband_time} + {1'b0, tick_time};
    mid_sat = mid_sum[TIME_W] ? {TIME_W{1'b1}} : mid_sum[TIME_W-1:0];
    hold_sum = {1'b0, out_hold_time} + {1'b0, tick_time};
  end

  always_comb begin
    flag              = DEC_NOP;
    mid_timeout       = 1'b0;
    midband_time_next = midband_time;
    if (below) begin
      midband_time_next = '0;
      if (multi) begin
        flag = DEC_OUT;
      end
    end else if (above) begin
      midband_time_next = '0;
      if ((in_tick.runnable_tasks > TASK_W'(n)) && (in_tick.current_freq > min_frequency)) begin
        flag = DEC_IN;
      end
    end else if (multi && (in_tick.min_queue_len < queue_limit)) begin
      if ((in_tick.min_queue_core_load < light_core_load) && (load < LOAD_W'(hi_prev))) begin
        midband_time_next = '0;
        flag              = DEC_OUT;
      end
    end else if (multi) begin
      if (mid_top) begin
        midband_time_next = '0;
      end else if (mid_low) begin
        if (mid_sat >= midband_limit) begin
          midband_time_next = '0;
          mid_timeout       = 1'b1;
        end else begin
          midband_time_next = mid_sat;
        end
      end
    end

    dec_next           = flag;
    out_hold_time_next = '0;
    if (mid_timeout) begin
      dec_next           = DEC_OUT;
      out_hold_time_next = out_hold_time;
    end else if (flag == DEC_OUT) begin
      if (hold_sum < {1'b0, out_hold_limit}) begin
        out_hold_time_next = hold_sum[TIME_W-1:0];
        dec_next           = DEC_NOP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      midband_time  <= '0;
      out_hold_time <= '0;
      res_valid     <= 1'b0;
    end else begin
      if (advance) begin
        midband_time  <= midband_time_next;
        out_hold_time <= out_hold_time_next;
        res_valid     <= 1'b1;
      end else if (m_axis_tready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_dec <= dec_next;
    end
  end

  a_dec_legal: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_dec == DEC_NOP || res_dec == DEC_IN || res_dec == DEC_OUT))
    else $error("illegal decision code");

  a_in_clears_hold: assert property (@(posedge clk) disable iff (rst)
    (advance && dec_next == DEC_IN) |=> (out_hold_time == '0 && midband_time == '0))
    else $error("plug-in left a timer running");

  a_timeout_keeps_hold: assert property (@(posedge clk) disable iff (rst)
    (advance && mid_timeout) |=> (out_hold_time == $past(out_hold_time) && res_dec == DEC_OUT))
    else $error("mid-band timeout disturbed hold timer");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!res_valid && !in_valid))
    else $error("pipeline valid after reset");

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks cpu_hotplug_decision_core. A driver streams sampling ticks from a
// queue and a monitor scores every decision against an in-bench model of the
// threshold selection, the mid-band timer and the plug-out hold timer.
// Stimulus runs directed corner ticks, then runs of well-formed random ticks
// aimed at each load band, under several register settings.
// ----------------------------------------------------------------------------
module testbench;
  import cphd_pkg::*;

  localparam int CORES_MAX   = 4;
  localparam int CYCLE_LIMIT = 120000;
  localparam int RUN_TICKS   = 183;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_AW-1:0]      cfg_addr = '0;
  logic [CFG_DW-1:0]      cfg_data = '0;

  logic [THR_W-1:0]   low_thr   = 32'h0000_0000;
  logic [THR_W-1:0]   high_thr  = 32'h6464_6464;
  logic [FREQ_W-1:0]  min_freq  = '0;
  logic [QLEN_W-1:0]  queue_lim = 8'd2;
  logic [CLOAD_W-1:0] light_ld  = 7'd20;
  logic [TIME_W-1:0]  tick_amt  = 16'd500;
  logic [TIME_W-1:0]  mid_lim   = 16'd8000;
  logic [TIME_W-1:0]  hold_lim  = 16'd2000;
  logic [TIME_W-1:0]  midband_acc = '0;
  logic [TIME_W-1:0]  hold_acc    = '0;

  tick_t     tick_q[$];
  decision_t decision_q[$];
  int        ticks_queued   = 0;
  int        ticks_taken    = 0;
  int        decisions_seen = 0;
  int        mismatches     = 0;
  int        cycle_cnt      = 0;
  int        stall_left     = 0;
  bit        stall_done     = 1'b0;
  bit        steady         = 1'b0;
  bit        in_taken       = 1'b0;

  cpu_hotplug_decision_core #(.MAX_CORES(CORES_MAX)) uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic int unsigned clamp_cores(int unsigned raw);
    if (raw == 0) return 1;
    if (raw > CORES_MAX) return CORES_MAX;
    return raw;
  endfunction

  function automatic logic [7:0] thr_of(logic [THR_W-1:0] r, int unsigned cores);
    int unsigned k;
    k = (cores - 1 > 3) ? 3 : cores - 1;
    return 8'(r >> (8 * k));
  endfunction

  function automatic decision_t predict_decision(tick_t tk);
    int unsigned   n;
    logic [7:0]    lo, hi, hp;
    logic [16:0]   sum;
    decision_t     d;
    n  = clamp_cores(tk.cores_online);
    lo = thr_of(low_thr, n);
    hi = thr_of(high_thr, n);
    hp = (n > 1) ? thr_of(high_thr, n - 1) : 8'd0;
    d  = DEC_NOP;
    if (tk.total_load < lo) begin
      midband_acc = '0;
      if (n > 1) d = DEC_OUT;
    end else if (tk.total_load > hi) begin
      midband_acc = '0;
      if (tk.runnable_tasks > n && tk.current_freq > min_freq) d = DEC_IN;
    end else if (n > 1 && tk.min_queue_len < queue_lim) begin
      if (tk.min_queue_core_load < light_ld && tk.total_load < hp) begin
        midband_acc = '0;
        d = DEC_OUT;
      end
    end else if (n > 1) begin
      if (tk.total_load >= hp && tk.total_load <= hi) begin
        midband_acc = '0;
      end else if (tk.total_load >= lo && tk.total_load < hp) begin
        sum = midband_acc + tick_amt;
        midband_acc = sum[16] ? 16'hFFFF : sum[15:0];
        // timeout plug-out bypasses the hold timer
        if (midband_acc >= mid_lim) begin
          midband_acc = '0;
          return DEC_OUT;
        end
      end
    end
    if (d == DEC_OUT) begin
      sum = hold_acc + tick_amt;
      if (sum < hold_lim) begin
        hold_acc = sum[15:0];
        d = DEC_NOP;
      end else begin
        hold_acc = '0;
      end
    end else begin
      hold_acc = '0;
    end
    return d;
  endfunction

  function automatic int unsigned pick_in(int lo_b, int hi_b, int unsigned fallback_max);
    if (lo_b <= hi_b) return $urandom_range(hi_b, lo_b);
    return $urandom_range(fallback_max, 0);
  endfunction

  // kind: 0 noise, 1 below low, 2 above high, 3 upper mid band,
  // 4 lower mid band, 5 light core out, 6 threshold edges
  function automatic tick_t make_tick(int kind, int unsigned cores_raw);
    tick_t       tk;
    int unsigned n;
    int          lo, hi, hp;
    n  = clamp_cores(cores_raw);
    lo = int'(thr_of(low_thr, n));
    hi = int'(thr_of(high_thr, n));
    hp = (n > 1) ? int'(thr_of(high_thr, n - 1)) : 0;
    tk.cores_online   = cores_raw[CORE_W-1:0];
    tk.current_freq   = ($urandom_range(0, 3) < 2) ? FREQ_W'($urandom) :
                        min_freq + FREQ_W'($urandom_range(0, 1));
    tk.runnable_tasks = $urandom_range(0, 1) ? TASK_W'($urandom) :
                        TASK_W'($urandom_range(0, 8));
    tk.min_queue_len  = QLEN_W'($urandom);
    tk.min_queue_core_load = CLOAD_W'($urandom);
    case (kind)
      1: tk.total_load = LOAD_W'(pick_in(0, lo - 1, 1023));
      2: tk.total_load = LOAD_W'(pick_in(hi + 1, 1023, 1023));
      3: begin
        tk.total_load    = LOAD_W'(pick_in(hp, hi, 1023));
        tk.min_queue_len = QLEN_W'(pick_in(queue_lim, 255, 255));
      end
      4: begin
        tk.total_load    = LOAD_W'(pick_in(lo, hp - 1, 1023));
        tk.min_queue_len = QLEN_W'(pick_in(queue_lim, 255, 255));
      end
      5: begin
        tk.total_load          = LOAD_W'(pick_in(lo, hp - 1, 1023));
        tk.min_queue_len       = QLEN_W'(pick_in(0, queue_lim - 1, 255));
        tk.min_queue_core_load = CLOAD_W'(pick_in(0, light_ld - 1, 127));
      end
      6: begin
        case ($urandom_range(0, 5))
          0: tk.total_load = LOAD_W'(lo);
          1: tk.total_load = LOAD_W'(hi);
          2: tk.total_load = LOAD_W'(hp);
          3: tk.total_load = LOAD_W'(hi + 1);
          4: tk.total_load = LOAD_W'((lo > 0) ? lo - 1 : 0);
          default: tk.total_load = LOAD_W'((hp > 0) ? hp - 1 : 0);
        endcase
        tk.min_queue_len       = queue_lim + QLEN_W'($urandom_range(0, 1)) - 1'b1;
        tk.min_queue_core_load = light_ld + CLOAD_W'($urandom_range(0, 1)) - 1'b1;
      end
      default: tk.total_load = LOAD_W'($urandom);
    endcase
    return tk;
  endfunction

  task automatic add_tick(int unsigned load, int unsigned freq, int unsigned cores,
                          int unsigned tasks, int unsigned qlen, int unsigned cload);
    tick_t tk;
    tk.total_load          = LOAD_W'(load);
    tk.current_freq        = FREQ_W'(freq);
    tk.cores_online        = CORE_W'(cores);
    tk.runnable_tasks      = TASK_W'(tasks);
    tk.min_queue_len       = QLEN_W'(qlen);
    tk.min_queue_core_load = CLOAD_W'(cload);
    tick_q.push_back(tk);
    ticks_queued++;
  endtask

  task automatic queue_runs(int count);
    int          kind, run_len, sel;
    int unsigned cores;
    while (count > 0) begin
      sel  = $urandom_range(0, 19);
      kind = (sel < 2) ? 0 : (sel < 10) ? 4 : (sel - 10) % 6 + 1;
      if (kind == 4) cores = $urandom_range(2, 4);
      else if ($urandom_range(0, 9) == 0) cores = $urandom_range(0, 7);
      else cores = $urandom_range(1, 4);
      run_len = $urandom_range(1, 24);
      if (run_len > count) run_len = count;
      repeat (run_len) begin
        tick_q.push_back(make_tick(kind, cores));
        ticks_queued++;
      end
      count -= run_len;
    end
  endtask

  task automatic drain();
    while (ticks_taken != ticks_queued || decision_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [CFG_DW-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_regs(logic [31:0] lo_v, logic [31:0] hi_v, logic [21:0] freq_v,
                              logic [7:0] ql_v, logic [6:0] light_v, logic [15:0] tick_v,
                              logic [15:0] mid_v, logic [15:0] hold_v);
    write_reg(CFG_LOW_THR, lo_v);
    write_reg(CFG_HIGH_THR, hi_v);
    write_reg(CFG_MIN_FREQ, CFG_DW'(freq_v));
    write_reg(CFG_QUEUE_LIM, CFG_DW'(ql_v));
    write_reg(CFG_LIGHT_LD, CFG_DW'(light_v));
    write_reg(CFG_TICK_TIME, CFG_DW'(tick_v));
    write_reg(CFG_MID_LIM, CFG_DW'(mid_v));
    write_reg(CFG_HOLD_LIM, CFG_DW'(hold_v));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic report_mismatch(string what);
    $display("ERROR t=%0t: %s", $time, what);
    mismatches++;
  endtask

  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (tick_q.size() != 0 && (steady || $urandom_range(0, 99) >= 21)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'(tick_q.pop_front());
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // hold off the result side once for a long stretch so the input backs up
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (!stall_done && decisions_seen >= 450) begin
      stall_done = 1'b1;
      stall_left = 200;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= steady || $urandom_range(0, 99) >= 21;
    end
  end

  always @(posedge clk) begin
    decision_t got, want;
    in_taken = 1'b0;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = decision_t'(m_axis_tdata[1:0]);
        decisions_seen++;
        if (decision_q.size() == 0) begin
          report_mismatch($sformatf("decision %0d with no request pending", got));
        end else begin
          want = decision_q.pop_front();
          if (got !== want)
            report_mismatch($sformatf("decision %0d, expected %0d (result %0d)",
                                      got, want, decisions_seen));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        in_taken = 1'b1;
        ticks_taken++;
        decision_q.push_back(predict_decision(tick_t'(s_axis_tdata[$bits(tick_t)-1:0])));
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_addr)
          CFG_LOW_THR:   low_thr   = cfg_data;
          CFG_HIGH_THR:  high_thr  = cfg_data;
          CFG_MIN_FREQ:  min_freq  = cfg_data[FREQ_W-1:0];
          CFG_QUEUE_LIM: queue_lim = cfg_data[QLEN_W-1:0];
          CFG_LIGHT_LD:  light_ld  = cfg_data[CLOAD_W-1:0];
          CFG_TICK_TIME: tick_amt  = cfg_data[TIME_W-1:0];
          CFG_MID_LIM:   mid_lim   = cfg_data[TIME_W-1:0];
          CFG_HOLD_LIM:  hold_lim  = cfg_data[TIME_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    logic [31:0] lo_r, hi_r;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    add_tick(0, 0, 0, 0, 0, 0);
    add_tick(1023, 22'h3FFFFF, 7, 16'hFFFF, 255, 127);
    add_tick(101, 0, 1, 5, 0, 0);
    add_tick(500, 1000, 4, 4, 0, 0);
    add_tick(500, 1000, 5, 5, 0, 0);
    add_tick(100, 77, 6, 9, 200, 50);
    repeat (4) add_tick(50, 1, 2, 1, 0, 0);
    add_tick(50, 1, 2, 1, 1, 20);
    add_tick(60, 1, 3, 1, 9, 127);
    add_tick(1023, 0, 3, 16'hFFFF, 9, 0);
    queue_runs(RUN_TICKS);
    drain();

    program_regs(32'h3C32_2800, 32'hC8B4_9650, 22'd100000, 8'd3, 7'd30,
                 16'd1000, 16'd5000, 16'd3000);
    queue_runs(RUN_TICKS);
    drain();

    program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 22'h3FFFFF, 8'hFF, 7'h7F,
                 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_runs(RUN_TICKS);
    drain();

    steady = 1'b1;
    program_regs(32'h0, 32'h0, 22'h0, 8'h0, 7'h0, 16'h0, 16'h0, 16'h0);
    queue_runs(RUN_TICKS);
    drain();
    steady = 1'b0;

    repeat (2) begin
      for (int k = 0; k < 4; k++) begin
        lo_r[8*k +: 8] = $urandom_range(0, 100);
        hi_r[8*k +: 8] = $urandom_range(100, 255);
      end
      program_regs(lo_r, hi_r, 22'($urandom), 8'($urandom_range(0, 12)),
                   7'($urandom), 16'($urandom_range(1, 3000)),
                   16'($urandom_range(0, 20000)), 16'($urandom_range(0, 10000)));
      queue_runs(RUN_TICKS);
      drain();
    end

    program_regs($urandom, $urandom, 22'($urandom), 8'($urandom), 7'($urandom),
                 16'd40000, 16'hFFFF, 16'hFFFF);
    queue_runs(RUN_TICKS);
    drain();

    repeat (8) @(negedge clk);
    if (mismatches == 0 && decision_q.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
